// File: hw/rtl/tpp_pkg.sv
// tpp_pkg: shared types and constants for the tof pixel pseudocolor block
// beat structs for the pixel and color channels, hsv stage types, divide constants
// no dependencies
package tpp_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  typedef enum logic [0:0] {
    REG_SATURATION = 1'b0,
    REG_VALUE      = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] SAT_RESET = 8'd255;
  localparam logic [7:0] VAL_RESET = 8'd255;

  // z / 200 as (z * 5243) >> 20, exact for z below 32768
  localparam logic [12:0] ZDIV_MUL   = 13'd5243;
  localparam int unsigned ZDIV_SHIFT = 20;
  // amplitude / 10 as (a * 3277) >> 15, exact for a below 2560
  localparam logic [11:0] ADIV_MUL   = 12'd3277;
  localparam int unsigned ADIV_SHIFT = 15;
  localparam logic [15:0] AMP_CLAMP  = 16'd2560;
  localparam logic [7:0]  HUE_MAX    = 8'd255;
  localparam logic [7:0]  FULL_SCALE = 8'd255;

  localparam logic [7:0] REGION_SPAN = 8'd43;
  localparam logic [7:0] REM_STEP    = 8'd6;

  typedef enum logic [2:0] {
    RGN_RED     = 3'd0,
    RGN_YELLOW  = 3'd1,
    RGN_GREEN   = 3'd2,
    RGN_CYAN    = 3'd3,
    RGN_BLUE    = 3'd4,
    RGN_MAGENTA = 3'd5
  } region_t;

  typedef struct packed {
    logic [7:0]         confidence;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic [15:0]        amplitude;
  } pix_in_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [7:0]         range_red;
    logic [7:0]         range_green;
    logic [7:0]         range_blue;
    logic [7:0]         intens_red;
    logic [7:0]         intens_green;
    logic [7:0]         intens_blue;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
    logic [15:0]        amplitude_out;
  } pix_out_t;

  typedef struct packed {
    logic       blank;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] region_base(region_t rg);
    logic [7:0] base;
    case (rg)
      RGN_RED:     base = 8'd0;
      RGN_YELLOW:  base = REGION_SPAN;
      RGN_GREEN:   base = 8'(2 * REGION_SPAN);
      RGN_CYAN:    base = 8'(3 * REGION_SPAN);
      RGN_BLUE:    base = 8'(4 * REGION_SPAN);
      RGN_MAGENTA: base = 8'(5 * REGION_SPAN);
      default:     base = 8'd0;
    endcase
    return base;
  endfunction

endpackage

// File: hw/rtl/tpp_hsv.sv
// tpp_hsv: three-stage pipelined 8-bit integer hsv to rgb conversion
// stages: region and products, q and t, color select with blanking
// depends on tpp_pkg
module tpp_hsv (
  input  logic            clk,
  input  logic            en,
  input  tpp_pkg::hsv_in_t hsv_in,
  output tpp_pkg::rgb_t    rgb
);

  // stage a
  tpp_pkg::region_t rg_a_next;
  logic [7:0]       diff_a;
  logic [7:0]       rem_a;
  logic [15:0]      p_prod_a;

  tpp_pkg::region_t rg_a;
  logic [15:0]      srem_a;
  logic [15:0]      sirem_a;
  logic [7:0]       p_a;
  logic [7:0]       v_a;
  logic             grey_a;
  logic             blank_a;

  always_comb begin
    if (hsv_in.hue >= 8'(5 * tpp_pkg::REGION_SPAN)) begin
      rg_a_next = tpp_pkg::RGN_MAGENTA;
    end else if (hsv_in.hue >= 8'(4 * tpp_pkg::REGION_SPAN)) begin
      rg_a_next = tpp_pkg::RGN_BLUE;
    end else if (hsv_in.hue >= 8'(3 * tpp_pkg::REGION_SPAN)) begin
      rg_a_next = tpp_pkg::RGN_CYAN;
    end else if (hsv_in.hue >= 8'(2 * tpp_pkg::REGION_SPAN)) begin
      rg_a_next = tpp_pkg::RGN_GREEN;
    end else if (hsv_in.hue >= tpp_pkg::REGION_SPAN) begin
      rg_a_next = tpp_pkg::RGN_YELLOW;
    end else begin
      rg_a_next = tpp_pkg::RGN_RED;
    end
    diff_a   = hsv_in.hue - tpp_pkg::region_base(rg_a_next);
    rem_a    = 8'(diff_a * tpp_pkg::REM_STEP);
    p_prod_a = 16'(hsv_in.val) * 16'(tpp_pkg::FULL_SCALE - hsv_in.sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg_a    <= rg_a_next;
      srem_a  <= 16'(hsv_in.sat) * 16'(rem_a);
      sirem_a <= 16'(hsv_in.sat) * 16'(tpp_pkg::FULL_SCALE - rem_a);
      p_a     <= p_prod_a[15:8];
      v_a     <= hsv_in.val;
      grey_a  <= (hsv_in.sat == 8'd0);
      blank_a <= hsv_in.blank;
    end
  end

  // stage b
  logic [15:0]      q_prod;
  logic [15:0]      t_prod;
  tpp_pkg::region_t rg_b;
  logic [7:0]       q_b;
  logic [7:0]       t_b;
  logic [7:0]       p_b;
  logic [7:0]       v_b;
  logic             grey_b;
  logic             blank_b;

  assign q_prod = 16'(v_a) * 16'(tpp_pkg::FULL_SCALE - srem_a[15:8]);
  assign t_prod = 16'(v_a) * 16'(tpp_pkg::FULL_SCALE - sirem_a[15:8]);

  always_ff @(posedge clk) begin
    if (en) begin
      rg_b    <= rg_a;
      q_b     <= q_prod[15:8];
      t_b     <= t_prod[15:8];
      p_b     <= p_a;
      v_b     <= v_a;
      grey_b  <= grey_a;
      blank_b <= blank_a;
    end
  end

  // stage c
  tpp_pkg::rgb_t rgb_next;

  always_comb begin
    case (rg_b)
      tpp_pkg::RGN_RED:     rgb_next = '{red: v_b, green: t_b, blue: p_b};
      tpp_pkg::RGN_YELLOW:  rgb_next = '{red: q_b, green: v_b, blue: p_b};
      tpp_pkg::RGN_GREEN:   rgb_next = '{red: p_b, green: v_b, blue: t_b};
      tpp_pkg::RGN_CYAN:    rgb_next = '{red: p_b, green: q_b, blue: v_b};
      tpp_pkg::RGN_BLUE:    rgb_next = '{red: t_b, green: p_b, blue: v_b};
      default:              rgb_next = '{red: v_b, green: p_b, blue: q_b};
    endcase
    if (grey_b) begin
      rgb_next = '{red: v_b, green: v_b, blue: v_b};
    end
    if (blank_b) begin
      rgb_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb <= rgb_next;
    end
  end

endmodule

// File: hw/rtl/tof_pixel_pseudocolor.sv
// tof_pixel_pseudocolor: top level, hue stage, pass-through pipeline and register port
// instantiates two tpp_hsv units; depends on tpp_pkg
//
// usage
// - pixel channel (pix_valid, pix_ready, pix_data): one time-of-flight pixel per beat
// - color channel (col_valid, col_ready, col_data): one result beat per pixel, in order
// - register port: apb-style, saturation at address 0, value at address 4, both reset to 255;
//   write only while no pixel is in flight
// - throughput: one pixel per cycle while not stalled; four register stages (hue divide, hsv
//   region and products, q/t products, color select) advance together on one shared enable
//   and carry an accepted pixel beat to its result beat on col_data
// - stall: while col_valid is high and col_ready low the whole pipeline holds and
//   pix_ready is low; an empty output stage keeps pix_ready high
// - reset: synchronous, clears all stage valid bits and sets both registers to 255
// - a nonzero confidence code gives pixel_valid 0 and all other fields 0
module tof_pixel_pseudocolor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  tpp_pkg::pix_in_t                  pix_data,
  output logic                              col_valid,
  input  logic                              col_ready,
  output tpp_pkg::pix_out_t                 col_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tpp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  typedef struct packed {
    logic               pixel_valid;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic [15:0]        amplitude;
  } pass_t;

  // register port
  logic [7:0]        sat;
  logic [7:0]        val;
  tpp_pkg::cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = tpp_pkg::cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= tpp_pkg::SAT_RESET;
      val <= tpp_pkg::VAL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        tpp_pkg::REG_SATURATION: sat <= pwdata[7:0];
        tpp_pkg::REG_VALUE:      val <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tpp_pkg::REG_SATURATION: prdata = tpp_pkg::CFG_DATA_W'(sat);
      tpp_pkg::REG_VALUE:      prdata = tpp_pkg::CFG_DATA_W'(val);
      default:                 prdata = '0;
    endcase
  end

  // pipeline control
  logic [3:0] vld;
  logic       en;

  assign en        = !vld[3] || col_ready;
  assign pix_ready = en;
  assign col_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], pix_valid};
    end
  end

  // hue stage
  logic        good;
  logic [27:0] z_prod;
  logic [23:0] a_prod;
  logic [7:0]  zhue_next;
  logic [7:0]  ahue_next;
  logic [7:0]  zhue;
  logic [7:0]  ahue;
  logic        blank;
  pass_t       pass [4];

  assign good   = (pix_data.confidence == 8'd0);
  assign z_prod = 28'(pix_data.z_coord[14:0]) * 28'(tpp_pkg::ZDIV_MUL);
  assign a_prod = 24'(pix_data.amplitude[11:0]) * 24'(tpp_pkg::ADIV_MUL);

  always_comb begin
    if (pix_data.z_coord[15]) begin
      zhue_next = 8'd0;
    end else begin
      zhue_next = z_prod[tpp_pkg::ZDIV_SHIFT +: 8];
    end
    if (pix_data.amplitude >= tpp_pkg::AMP_CLAMP) begin
      ahue_next = tpp_pkg::HUE_MAX;
    end else begin
      ahue_next = a_prod[tpp_pkg::ADIV_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zhue  <= zhue_next;
      ahue  <= ahue_next;
      blank <= !good;
      if (good) begin
        pass[0] <= '{pixel_valid: 1'b1, x_coord: pix_data.x_coord, y_coord: pix_data.y_coord,
                     z_coord: pix_data.z_coord, amplitude: pix_data.amplitude};
      end else begin
        pass[0] <= '0;
      end
      pass[1] <= pass[0];
      pass[2] <= pass[1];
      pass[3] <= pass[2];
    end
  end

  // color conversion
  tpp_pkg::hsv_in_t range_hsv;
  tpp_pkg::hsv_in_t intens_hsv;
  tpp_pkg::rgb_t    range_rgb;
  tpp_pkg::rgb_t    intens_rgb;

  assign range_hsv  = '{blank: blank, hue: zhue, sat: sat, val: val};
  assign intens_hsv = '{blank: blank, hue: ahue, sat: sat, val: val};

  tpp_hsv u_range_hsv (
    .clk    (clk),
    .en     (en),
    .hsv_in (range_hsv),
    .rgb    (range_rgb)
  );

  tpp_hsv u_intens_hsv (
    .clk    (clk),
    .en     (en),
    .hsv_in (intens_hsv),
    .rgb    (intens_rgb)
  );

  assign col_data = '{
    pixel_valid:   pass[3].pixel_valid,
    range_red:     range_rgb.red,
    range_green:   range_rgb.green,
    range_blue:    range_rgb.blue,
    intens_red:    intens_rgb.red,
    intens_green:  intens_rgb.green,
    intens_blue:   intens_rgb.blue,
    x_out:         pass[3].x_coord,
    y_out:         pass[3].y_coord,
    z_out:         pass[3].z_coord,
    amplitude_out: pass[3].amplitude
  };

endmodule

// File: hw/rtl/tpp_checker.sv
// tpp_checker: port-level checks for tof_pixel_pseudocolor, bound to the top level
// depends on tpp_pkg
module tpp_checker (
  input logic              clk,
  input logic              rst,
  input logic              pix_ready,
  input logic              col_valid,
  input logic              col_ready,
  input tpp_pkg::pix_out_t col_data
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    col_valid && !col_ready |=> col_valid && $stable(col_data))
    else $error("result beat changed while stalled");

  // an invalid pixel carries only zeros
  a_blank: assert property (@(posedge clk) disable iff (rst)
    col_valid && !col_data.pixel_valid |->
      col_data.range_red == 8'd0 && col_data.range_green == 8'd0 &&
      col_data.range_blue == 8'd0 && col_data.intens_red == 8'd0 &&
      col_data.intens_green == 8'd0 && col_data.intens_blue == 8'd0 &&
      col_data.x_out == 16'sd0 && col_data.y_out == 16'sd0 &&
      col_data.z_out == 16'sd0 && col_data.amplitude_out == 16'd0)
    else $error("invalid pixel with nonzero fields");

  // a draining sink never blocks the pixel side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    col_ready || !col_valid |-> pix_ready)
    else $error("pixel side stalled without back pressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !col_valid)
    else $error("result beat right after reset");

endmodule

bind tof_pixel_pseudocolor tpp_checker u_tpp_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix_ready),
  .col_valid (col_valid),
  .col_ready (col_ready),
  .col_data  (col_data)
);

// File: verif/tb.sv
// tb: self-checking testbench for tof_pixel_pseudocolor, pixel in and color out beats
// predicts each color beat from the accepted pixel and the register copy, checks in order
// depends on tpp_pkg and tof_pixel_pseudocolor
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic pix_valid = 1'b0;
  logic pix_ready;
  tpp_pkg::pix_in_t pix_data = '0;
  logic col_valid;
  logic col_ready = 1'b0;
  tpp_pkg::pix_out_t col_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tpp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [tpp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [tpp_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  tpp_pkg::pix_in_t pixel_queue[$];
  tpp_pkg::pix_out_t color_expect[$];

  logic [7:0] sat_copy = tpp_pkg::SAT_RESET;
  logic [7:0] val_copy = tpp_pkg::VAL_RESET;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int unsigned fail_count = 0;

  tof_pixel_pseudocolor u_top (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
    .col_valid(col_valid), .col_ready(col_ready), .col_data(col_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic tpp_pkg::rgb_t hsv_color(logic [7:0] hue, logic [7:0] sat,
                                              logic [7:0] val);
    tpp_pkg::rgb_t c;
    int unsigned h, s, v, sector, frac, lo, fall, rise;
    h = hue;
    s = sat;
    v = val;
    if (s == 0) begin
      c.red = val;
      c.green = val;
      c.blue = val;
      return c;
    end
    sector = h / 43;
    frac = (h - sector * 43) * 6;
    lo = (v * (255 - s)) >> 8;
    fall = (v * (255 - ((s * frac) >> 8))) >> 8;
    rise = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
    case (sector)
      0: begin c.red = 8'(v); c.green = 8'(rise); c.blue = 8'(lo); end
      1: begin c.red = 8'(fall); c.green = 8'(v); c.blue = 8'(lo); end
      2: begin c.red = 8'(lo); c.green = 8'(v); c.blue = 8'(rise); end
      3: begin c.red = 8'(lo); c.green = 8'(fall); c.blue = 8'(v); end
      4: begin c.red = 8'(rise); c.green = 8'(lo); c.blue = 8'(v); end
      default: begin c.red = 8'(v); c.green = 8'(lo); c.blue = 8'(fall); end
    endcase
    return c;
  endfunction

  function automatic tpp_pkg::pix_out_t predict_pixel(tpp_pkg::pix_in_t p);
    tpp_pkg::pix_out_t r;
    int unsigned zq, aq;
    tpp_pkg::rgb_t dc, ac;
    r = '0;
    if (p.confidence != 8'd0) return r;
    // negative depth maps to hue 0
    zq = p.z_coord[15] ? 0 : int'(p.z_coord[14:0]) / 200;
    if (zq > 255) zq = 255;
    aq = int'(p.amplitude) / 10;
    if (aq > 255) aq = 255;
    dc = hsv_color(8'(zq), sat_copy, val_copy);
    ac = hsv_color(8'(aq), sat_copy, val_copy);
    r.pixel_valid = 1'b1;
    r.range_red = dc.red;
    r.range_green = dc.green;
    r.range_blue = dc.blue;
    r.intens_red = ac.red;
    r.intens_green = ac.green;
    r.intens_blue = ac.blue;
    r.x_out = p.x_coord;
    r.y_out = p.y_coord;
    r.z_out = p.z_coord;
    r.amplitude_out = p.amplitude;
    return r;
  endfunction

  function automatic tpp_pkg::pix_in_t make_pixel(logic [7:0] conf, logic [15:0] x,
                                                  logic [15:0] y, logic [15:0] z,
                                                  logic [15:0] amp);
    tpp_pkg::pix_in_t p;
    p.confidence = conf;
    p.x_coord = x;
    p.y_coord = y;
    p.z_coord = z;
    p.amplitude = amp;
    return p;
  endfunction

  function automatic tpp_pkg::pix_in_t random_pixel();
    logic [7:0] conf;
    logic [15:0] z, amp;
    conf = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    case ($urandom_range(0, 3))
      0: z = 16'($urandom);
      1: z = 16'($urandom_range(0, 400));
      default: z = 16'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(0, 3))
      0: amp = 16'($urandom);
      1: amp = 16'($urandom_range(2500, 2600));
      default: amp = 16'($urandom_range(0, 2559));
    endcase
    return make_pixel(conf, 16'($urandom), 16'($urandom), z, amp);
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, want, got);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pix_valid && pix_ready) color_expect.push_back(predict_pixel(pix_data));
      if (!pix_valid || pix_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          pix_valid <= 1'b0;
        end else if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pix_valid <= 1'b1;
          pix_data <= pixel_queue.pop_front();
        end else begin
          if (pixel_queue.size() != 0) send_gap <= $urandom_range(0, 12);
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // color receiver
  always @(posedge clk) begin
    if (rst) begin
      col_ready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      recv_gap <= 80;
      col_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      col_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap <= $urandom_range(0, 12);
      col_ready <= 1'b0;
    end else begin
      col_ready <= 1'b1;
    end
  end

  // color monitor
  always @(posedge clk) begin
    tpp_pkg::pix_out_t want;
    if (!rst && col_valid && col_ready) begin
      if (color_expect.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected color beat %0h", col_data);
      end else begin
        want = color_expect.pop_front();
        report_field("pixel_valid", 16'(want.pixel_valid), 16'(col_data.pixel_valid));
        report_field("range_red", 16'(want.range_red), 16'(col_data.range_red));
        report_field("range_green", 16'(want.range_green), 16'(col_data.range_green));
        report_field("range_blue", 16'(want.range_blue), 16'(col_data.range_blue));
        report_field("intens_red", 16'(want.intens_red), 16'(col_data.intens_red));
        report_field("intens_green", 16'(want.intens_green), 16'(col_data.intens_green));
        report_field("intens_blue", 16'(want.intens_blue), 16'(col_data.intens_blue));
        report_field("x_out", want.x_out, col_data.x_out);
        report_field("y_out", want.y_out, col_data.y_out);
        report_field("z_out", want.z_out, col_data.z_out);
        report_field("amplitude_out", want.amplitude_out, col_data.amplitude_out);
      end
    end
  end

  task automatic write_reg(tpp_pkg::cfg_reg_t idx, logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tpp_pkg::REG_SATURATION) sat_copy = value;
    else val_copy = value;
  endtask

  task automatic drain();
    do @(posedge clk); while (pixel_queue.size() != 0 || pix_valid || color_expect.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(logic [7:0] sat, logic [7:0] val, int unsigned count,
                           int unsigned s_pct, int unsigned r_pct);
    write_reg(tpp_pkg::REG_SATURATION, sat);
    write_reg(tpp_pkg::REG_VALUE, val);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) pixel_queue.push_back(random_pixel());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // field extremes, invalid codes, depth and amplitude clamps, region edges
    pixel_queue.push_back(make_pixel(8'd0, 16'h8000, 16'h7fff, 16'd0, 16'd0));
    pixel_queue.push_back(make_pixel(8'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff));
    pixel_queue.push_back(make_pixel(8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    pixel_queue.push_back(make_pixel(8'd1, 16'h1234, 16'h8000, 16'h7fff, 16'd500));
    pixel_queue.push_back(make_pixel(8'd128, 16'h7fff, 16'h5555, 16'd1000, 16'd1000));
    pixel_queue.push_back(make_pixel(8'd0, 16'hffff, 16'h0001, 16'hffff, 16'd9));
    pixel_queue.push_back(make_pixel(8'd0, 16'h0000, 16'hffff, 16'h8000, 16'd10));
    pixel_queue.push_back(make_pixel(8'd0, 16'haaaa, 16'h5555, 16'd199, 16'd2559));
    pixel_queue.push_back(make_pixel(8'd0, 16'h5555, 16'haaaa, 16'd200, 16'd2560));
    pixel_queue.push_back(make_pixel(8'd0, 16'd3, 16'd4, 16'd8600, 16'd420));
    pixel_queue.push_back(make_pixel(8'd0, 16'd5, 16'd6, 16'd17000, 16'd860));
    pixel_queue.push_back(make_pixel(8'd0, 16'd7, 16'd8, 16'd17200, 16'd1280));
    pixel_queue.push_back(make_pixel(8'd0, 16'd9, 16'd10, 16'd25800, 16'd1710));
    pixel_queue.push_back(make_pixel(8'd0, 16'd11, 16'd12, 16'd32600, 16'd1720));
    pixel_queue.push_back(make_pixel(8'd0, 16'd13, 16'd14, 16'd8599, 16'd2140));
    pixel_queue.push_back(make_pixel(8'd0, 16'd15, 16'd16, 16'd17199, 16'd2150));
    pixel_queue.push_back(make_pixel(8'd0, 16'd17, 16'd18, 16'd25799, 16'd2550));
    pixel_queue.push_back(make_pixel(8'd0, 16'd19, 16'd20, 16'd4, 16'd2590));
    repeat (250) pixel_queue.push_back(random_pixel());
    drain();

    // zero saturation, with a long receiver hold while pixels keep coming
    hold_req = 1'b1;
    run_phase(8'd0, 8'd255, 200, 0, 10);
    run_phase(8'd255, 8'd0, 200, 15, 15);
    run_phase(8'd0, 8'd0, 150, 30, 5);
    run_phase(8'd1, 8'd254, 250, 0, 0);
    run_phase(8'($urandom), 8'($urandom), 250, 50, 50);
    run_phase(8'($urandom), 8'($urandom), 250, 10, 40);
    // tail without idling
    run_phase(8'd128, 8'd200, 300, 0, 0);

    if (fail_count == 0) begin
      $display("** tof_pixel_pseudocolor: PASSED **");
    end else begin
      $display("** tof_pixel_pseudocolor: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** tof_pixel_pseudocolor: FAILED **");
    $finish;
  end

endmodule
